### hw/rtl/tpo_pkg.sv
// ----------------------------------------------------------------------------
// tpo_pkg
// Fixed port widths and field layout of the triangle pair overlap test.
// ----------------------------------------------------------------------------
package tpo_pkg;

  localparam int VERT_BITS   = 63;
  localparam int NUM_VERTS   = 6;
  localparam int S_DATA_BITS = 384;
  localparam int M_DATA_BITS = 8;
  localparam int NUM_AXES    = 17;

endpackage

### hw/rtl/triangle_pair_overlap_test.sv
// ----------------------------------------------------------------------------
// triangle_pair_overlap_test
// Separating axis test of two triangles over seventeen axes, exact integers.
// ----------------------------------------------------------------------------
// Pipeline: 7 register stages, named stage 1 to stage 7 below.
// Throughput: one request per cycle; the whole pipeline holds while the
//   output register is full and not taken.
// Rate is set by the seven-stage pipeline with split two-stage multipliers.
// Reset (rst, synchronous): clears all valid bits; payload is not reset.
module triangle_pair_overlap_test import tpo_pkg::*; #(
  parameter int COORD_BITS = 21
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // vertex_p1, vertex_p2, vertex_p3, vertex_q1, vertex_q2, vertex_q3 (63 each)
  input  logic [S_DATA_BITS-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // contact
  output logic [M_DATA_BITS-1:0] m_tdata
);

  localparam int CB = COORD_BITS;
  localparam int D  = CB + 1;
  localparam int DW = 2 * D + 1;
  localparam int PW = 2 * DW;
  localparam int CW = DW + D;

  logic       en;
  logic [6:0] vld;
  logic       contact;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[6];
  assign m_tdata  = {{(M_DATA_BITS-1){1'b0}}, contact};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], s_tvalid};
    end
  end

  function automatic logic signed [DW-1:0] xd(
    input logic signed [D-1:0] a, b, c, d
  );
    logic signed [2*D-1:0] p0;
    logic signed [2*D-1:0] p1;
    p0 = a * b;
    p1 = c * d;
    return DW'(p0) - DW'(p1);
  endfunction

  function automatic logic signed [DW-1:0] dt(
    input logic signed [D-1:0] a0, a1, a2, b0, b1, b2
  );
    logic signed [2*D-1:0] p0;
    logic signed [2*D-1:0] p1;
    logic signed [2*D-1:0] p2;
    p0 = a0 * b0;
    p1 = a1 * b1;
    p2 = a2 * b2;
    return DW'(p0) + DW'(p1) + DW'(p2);
  endfunction

  function automatic logic signed [PW-1:0] mn3(
    input logic signed [PW-1:0] a, b, c
  );
    logic signed [PW-1:0] m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  function automatic logic signed [PW-1:0] mx3(
    input logic signed [PW-1:0] a, b, c
  );
    logic signed [PW-1:0] m;
    m = (a < b) ? b : a;
    return (m < c) ? c : m;
  endfunction

  // stage 1: unpack, translate to the first vertex of P, form edges
  logic signed [CB-1:0] crd [NUM_VERTS][3];
  logic signed [D-1:0]  pt  [NUM_VERTS][3];
  logic signed [D-1:0]  ed  [NUM_VERTS][3];

  for (genvar k = 0; k < NUM_VERTS; k++) begin : g_s1
    localparam int NX = (k < 3) ? (k + 1) % 3 : 3 + (k - 2) % 3;
    for (genvar c = 0; c < 3; c++) begin : g_c
      assign crd[k][c] = s_tdata[k*VERT_BITS + c*CB +: CB];
      always_ff @(posedge clk) begin
        if (en) begin
          pt[k][c] <= D'(crd[k][c]) - D'(crd[0][c]);
          ed[k][c] <= D'(crd[NX][c]) - D'(crd[k][c]);
        end
      end
    end
  end

  // stage 2: cross product axes, edge dot products, point projections on edges
  logic signed [DW-1:0] ax  [11][3];
  logic signed [DW-1:0] tk  [6][2];
  logic signed [DW-1:0] pb  [2][2][NUM_VERTS];
  logic signed [D-1:0]  pt2 [NUM_VERTS][3];

  for (genvar a = 0; a < 11; a++) begin : g_ax
    localparam int IA = (a < 9) ? a / 3 : ((a == 9) ? 0 : 3);
    localparam int IB = (a < 9) ? 3 + a % 3 : ((a == 9) ? 1 : 4);
    always_ff @(posedge clk) begin
      if (en) begin
        ax[a][0] <= xd(ed[IA][1], ed[IB][2], ed[IA][2], ed[IB][1]);
        ax[a][1] <= xd(ed[IA][2], ed[IB][0], ed[IA][0], ed[IB][2]);
        ax[a][2] <= xd(ed[IA][0], ed[IB][1], ed[IA][1], ed[IB][0]);
      end
    end
  end

  for (genvar t = 0; t < 6; t++) begin : g_tk
    localparam int B0 = (t / 3) * 3;
    for (genvar h = 0; h < 2; h++) begin : g_h
      always_ff @(posedge clk) begin
        if (en) begin
          tk[t][h] <= dt(ed[t][0], ed[t][1], ed[t][2],
                         ed[B0+h][0], ed[B0+h][1], ed[B0+h][2]);
        end
      end
    end
  end

  for (genvar s = 0; s < 2; s++) begin : g_pb
    for (genvar h = 0; h < 2; h++) begin : g_h
      for (genvar k = 0; k < NUM_VERTS; k++) begin : g_k
        always_ff @(posedge clk) begin
          if (en) begin
            pb[s][h][k] <= dt(ed[3*s+h][0], ed[3*s+h][1], ed[3*s+h][2],
                              pt[k][0], pt[k][1], pt[k][2]);
          end
        end
      end
    end
  end

  for (genvar k = 0; k < NUM_VERTS; k++) begin : g_pt2
    always_ff @(posedge clk) begin
      if (en) begin
        pt2[k] <= pt[k];
      end
    end
  end

  // stages 3 and 4: projection products
  logic signed [CW-1:0] cp [11][NUM_VERTS][3];
  logic signed [PW-1:0] tp [6][NUM_VERTS][2];

  for (genvar a = 0; a < 11; a++) begin : g_cm
    for (genvar k = 0; k < NUM_VERTS; k++) begin : g_k
      for (genvar c = 0; c < 3; c++) begin : g_c
        tpo_mul #(.AW(DW), .BW(D)) u_mul (
          .clk (clk),
          .en  (en),
          .a   (ax[a][c]),
          .b   (pt2[k][c]),
          .p   (cp[a][k][c])
        );
      end
    end
  end

  // (e x (e0 x e1)) . x = (e.e1)(e0.x) - (e.e0)(e1.x)
  for (genvar t = 0; t < 6; t++) begin : g_tm
    for (genvar k = 0; k < NUM_VERTS; k++) begin : g_k
      tpo_mul #(.AW(DW), .BW(DW)) u_mul0 (
        .clk (clk),
        .en  (en),
        .a   (tk[t][1]),
        .b   (pb[t/3][0][k]),
        .p   (tp[t][k][0])
      );
      tpo_mul #(.AW(DW), .BW(DW)) u_mul1 (
        .clk (clk),
        .en  (en),
        .a   (tk[t][0]),
        .b   (pb[t/3][1][k]),
        .p   (tp[t][k][1])
      );
    end
  end

  // stage 5: projections
  logic signed [PW-1:0] pj [NUM_AXES][NUM_VERTS];

  for (genvar k = 0; k < NUM_VERTS; k++) begin : g_pj
    for (genvar a = 0; a < 11; a++) begin : g_c
      always_ff @(posedge clk) begin
        if (en) begin
          pj[a][k] <= PW'(cp[a][k][0]) + PW'(cp[a][k][1]) + PW'(cp[a][k][2]);
        end
      end
    end
    for (genvar t = 0; t < 6; t++) begin : g_t
      always_ff @(posedge clk) begin
        if (en) begin
          pj[11+t][k] <= tp[t][k][0] - tp[t][k][1];
        end
      end
    end
  end

  // stage 6: interval ends; stage 7: separation and result
  logic signed [PW-1:0] pmin [NUM_AXES];
  logic signed [PW-1:0] pmax [NUM_AXES];
  logic signed [PW-1:0] qmin [NUM_AXES];
  logic signed [PW-1:0] qmax [NUM_AXES];
  logic [NUM_AXES-1:0]  sep;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_iv
    always_ff @(posedge clk) begin
      if (en) begin
        pmin[a] <= mn3(pj[a][0], pj[a][1], pj[a][2]);
        pmax[a] <= mx3(pj[a][0], pj[a][1], pj[a][2]);
        qmin[a] <= mn3(pj[a][3], pj[a][4], pj[a][5]);
        qmax[a] <= mx3(pj[a][3], pj[a][4], pj[a][5]);
      end
    end
    // touching ends count as contact
    assign sep[a] = (qmax[a] < pmin[a]) || (pmax[a] < qmin[a]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      contact <= ~|sep;
    end
  end

endmodule

### hw/rtl/tpo_mul.sv
// ----------------------------------------------------------------------------
// tpo_mul
// Signed multiplier split into four partial products, two register stages.
// ----------------------------------------------------------------------------
module tpo_mul #(
  parameter int AW = 46,
  parameter int BW = 46
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [AW-1:0]       a,
  input  logic signed [BW-1:0]       b,
  output logic signed [AW+BW-1:0]    p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PWD = AW + BW;

  logic signed [AH-1:0] ah;
  logic        [AL-1:0] al;
  logic signed [BH-1:0] bh;
  logic        [BL-1:0] bl;

  logic signed [AH+BH-1:0] pp_hh;
  logic signed [AH+BL:0]   pp_hl;
  logic signed [AL+BH:0]   pp_lh;
  logic        [AL+BL-1:0] pp_ll;

  assign ah = a[AW-1:AL];
  assign al = a[AL-1:0];
  assign bh = b[BW-1:BL];
  assign bl = b[BL-1:0];

  // low halves are unsigned, high halves carry the sign
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= ah * bh;
      pp_hl <= ah * $signed({1'b0, bl});
      pp_lh <= $signed({1'b0, al}) * bh;
      pp_ll <= al * bl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (PWD'(pp_hh) <<< (AL + BL)) + (PWD'(pp_hl) <<< AL)
         + (PWD'(pp_lh) <<< BL) + PWD'(pp_ll);
    end
  end

endmodule
